### rtl/core/kss_pkg.sv
// Shared constants, codes and port structs for the shared-store stack block.
`timescale 1ns / 1ps

package kss_pkg;

  localparam int NUM_STACKS = 4;
  localparam int NUM_SLOTS  = 32;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int DATA_W     = 32;

  // A null link or head is the value NUM_SLOTS.
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_SLOTS);

  // Request codes.
  localparam logic [1:0] REQ_PUSH = 2'd0;
  localparam logic [1:0] REQ_POP  = 2'd1;
  localparam logic [1:0] REQ_PEEK = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              data_we;
    logic              link_we;
    logic [SLOT_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [LINK_W-1:0] wr_link;
  } kss_mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] rd_data;
    logic [LINK_W-1:0] rd_link;
  } kss_mem_rsp_t;

  // Link value of a slot after reset: the next slot, null for the last one.
  function automatic logic [LINK_W-1:0] kss_link_init(input logic [SLOT_W-1:0] idx);
    logic [LINK_W-1:0] res;
    if (LINK_W'(idx) == LINK_W'(NUM_SLOTS - 1)) begin
      res = NULL_LINK;
    end else begin
      res = LINK_W'(idx) + LINK_W'(1);
    end
    return res;
  endfunction

endpackage

### rtl/core/kss_store.sv
// Slot data and slot link memories with a registered read port.
`timescale 1ns / 1ps

module kss_store
  import kss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  kss_mem_req_t req,
  output kss_mem_rsp_t rsp
);

  logic [DATA_W-1:0] data_mem [NUM_SLOTS];
  logic [LINK_W-1:0] link_mem [NUM_SLOTS];
  // A link entry that was never written reads as its reset value.
  logic [NUM_SLOTS-1:0] link_vld_r;
  logic [DATA_W-1:0]    rd_data_r;
  logic [LINK_W-1:0]    rd_link_r;

  always_ff @(posedge clk) begin
    if (req.data_we) begin
      data_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.link_we) begin
      link_mem[req.wr_addr] <= req.wr_link;
    end
    if (req.rd_en) begin
      rd_data_r <= data_mem[req.rd_addr];
      rd_link_r <= link_vld_r[req.rd_addr] ? link_mem[req.rd_addr]
                                            : kss_link_init(req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_vld_r <= '0;
    end else if (req.link_we) begin
      link_vld_r[req.wr_addr] <= 1'b1;
    end
  end

  assign rsp.rd_data = rd_data_r;
  assign rsp.rd_link = rd_link_r;

endmodule

### rtl/core/k_stacks_shared_store.sv
// Top level: several stacks sharing one slot store through a linked free list.
`timescale 1ns / 1ps
// Timing: an accepted request item is captured with its slot read; its result is loaded into the output
// register in the execute step when that register is free, else it waits there until the register drains.
// A new item is taken only in the idle state, once the last one has left the execute step, since
// the slot store's registered read is followed by the write-back of link, data and heads.
// Reset: every stack is empty and the free list runs through the slots in order;
// link valid bits stand in for the initial links, so there is no clearing pass.

module k_stacks_shared_store
  import kss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] push_value
  input  logic [3:0]  in_tuser,   // [1:0] req_type, [3:2] stack_id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] top_value
  output logic [1:0]  out_tuser   // [1:0] status
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;

  // Captured request and the slot address it selected at accept time.
  logic [1:0]        op_r;
  logic [1:0]        sid_r;
  logic [DATA_W-1:0] val_r;
  logic [LINK_W-1:0] slot_r;

  // Stack heads and the free-list head stay in flip-flops; they are tiny.
  logic [LINK_W-1:0] head_r [NUM_STACKS];
  logic [LINK_W-1:0] head_nxt;
  logic              head_we;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;

  // Output register, so a finished result can wait while the next item is taken.
  logic              out_valid_r;
  logic [1:0]        out_status_r, status_nxt;
  logic [DATA_W-1:0] out_value_r, value_nxt;

  logic              in_fire;
  logic              exec_go;
  logic              slot_null;
  logic [1:0]        in_op;
  logic [1:0]        in_sid;
  logic [LINK_W-1:0] sel_addr;

  kss_mem_req_t mem_req;
  kss_mem_rsp_t mem_rsp;

  kss_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rsp   (mem_rsp)
  );

  assign in_op     = in_tuser[1:0];
  assign in_sid    = in_tuser[3:2];
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;

  // A push reads the slot at the free-list head; pop and peek read the stack top.
  assign sel_addr = (in_op == REQ_PUSH) ? free_head_r : head_r[in_sid];

  // The result can be loaded once the output register is empty or draining.
  assign exec_go   = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign slot_null = (slot_r >= NULL_LINK);

  // Read-modify-write of the linked structure. Memory data read at accept time
  // is available here; both a push and a pop write the link of the slot they
  // touch, so the write address is always the captured slot.
  always_comb begin
    status_nxt    = ST_OK;
    value_nxt     = '0;
    free_head_nxt = free_head_r;
    head_nxt      = head_r[sid_r];
    head_we       = 1'b0;

    mem_req.rd_en   = in_fire;
    mem_req.rd_addr = sel_addr[SLOT_W-1:0];
    mem_req.data_we = 1'b0;
    mem_req.link_we = 1'b0;
    mem_req.wr_addr = slot_r[SLOT_W-1:0];
    mem_req.wr_data = val_r;
    mem_req.wr_link = head_r[sid_r];

    case (op_r)
      REQ_PUSH: begin
        if (slot_null) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          // Take the free slot, store the value and link it above the old top.
          free_head_nxt   = mem_rsp.rd_link;
          head_nxt        = slot_r;
          head_we         = exec_go;
          mem_req.data_we = exec_go;
          mem_req.link_we = exec_go;
          mem_req.wr_link = head_r[sid_r];
        end
      end
      REQ_POP: begin
        if (slot_null) begin
          status_nxt = ST_EMPTY;
        end else begin
          // The old link becomes the new top, and the slot is relinked
          // onto the free list.
          value_nxt       = mem_rsp.rd_data;
          head_nxt        = mem_rsp.rd_link;
          head_we         = exec_go;
          free_head_nxt   = slot_r;
          mem_req.link_we = exec_go;
          mem_req.wr_link = free_head_r;
        end
      end
      REQ_PEEK: begin
        if (slot_null) begin
          status_nxt = ST_EMPTY;
        end else begin
          value_nxt = mem_rsp.rd_data;
        end
      end
      default: begin
        // The unused request code is ignored and answers ok with zero.
        status_nxt = ST_OK;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= REQ_PUSH;
      sid_r        <= '0;
      val_r        <= '0;
      slot_r       <= NULL_LINK;
      free_head_r  <= '0;
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_r[i] <= NULL_LINK;
      end
      out_valid_r  <= 1'b0;
      out_status_r <= ST_OK;
      out_value_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        op_r   <= in_op;
        sid_r  <= in_sid;
        val_r  <= in_tdata;
        slot_r <= sel_addr;
      end
      if (exec_go) begin
        free_head_r  <= free_head_nxt;
        out_status_r <= status_nxt;
        out_value_r  <= value_nxt;
        if (head_we) begin
          head_r[sid_r] <= head_nxt;
        end
      end
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTH
  // An accepted item always moves on to the execute step.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted item did not enter the execute step");

  // Finishing the execute step always presents a result.
  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    exec_go |=> out_valid_r)
    else $error("execute step finished without a result");

  // Any error status carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_value_r == '0))
    else $error("error result carries a nonzero value");

  // A successful pop puts its slot at the head of the free list.
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_go && (op_r == REQ_POP) && !slot_null) |=> (free_head_r == $past(slot_r)))
    else $error("popped slot not returned to the free list");
`endif

endmodule
